### sv/swft_pkg.sv
`timescale 1ns / 1ps

package swft_pkg;

    localparam int SINE_TABLE_ENTRIES_DEF = 256;
    localparam int LATENCY = 8;

    localparam logic [15:0] Q15_ONE = 16'd32768;
    localparam logic [15:0] Q15_HALF = 16'd16384;
    localparam logic [15:0] K_0P8 = 16'd26214;
    localparam logic [15:0] K_0P4 = 16'd13107;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [12:0] CLEAR_RESET = 13'd410;

    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] sz;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        logic signed [15:0] ez;
    } t_ends;

    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] sz;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic signed [20:0] ca;
        logic signed [20:0] cb;
    } t_geom;

    // Taylor series of sin(x) for x in Q30, rounded to Q15 and held in [0, 1.0].
    function automatic logic [15:0] sine_q15(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic [63:0] s;
        x2 = (x * x) >> 30;
        sum = $signed(x);
        term = ((x * x2) >> 30) / 64'd6;
        sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd272;
        sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd342;
        sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd420;
        sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd506;
        sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd600;
        sum = sum + $signed(term);
        if (sum < 0) begin
            sum = '0;
        end
        s = ($unsigned(sum) + 64'd16384) >> 15;
        if (s > 64'(Q15_ONE)) begin
            s = 64'(Q15_ONE);
        end
        return s[15:0];
    endfunction

    // Differences and parabola coefficients for one item.
    function automatic t_geom geom_prep(input t_ends e, input logic [12:0] clr);
        t_geom g;
        logic signed [15:0] hi;
        logic signed [17:0] d_end;
        logic signed [18:0] d_mid;
        hi = (e.ez > e.sz) ? e.ez : e.sz;
        d_end = 18'(e.ez) - 18'(e.sz);
        d_mid = 19'(hi) - 19'(e.sz) + $signed({6'd0, clr});
        g.sx = e.sx;
        g.sy = e.sy;
        g.sz = e.sz;
        g.dx = 17'(e.ex) - 17'(e.sx);
        g.dy = 17'(e.ey) - 17'(e.sy);
        g.ca = (21'(d_end) <<< 1) - (21'(d_mid) <<< 2);
        g.cb = (21'(d_mid) <<< 2) - 21'(d_end);
        return g;
    endfunction

    // Rounding to nearest with ties away from zero, by 2^15 and by 2^30.
    function automatic logic signed [20:0] round_q15(input logic signed [35:0] v);
        logic signed [35:0] t;
        t = v + (v[35] ? 36'sd16383 : 36'sd16384);
        return t[35:15];
    endfunction

    function automatic logic signed [25:0] round_q30(input logic signed [55:0] v);
        logic signed [55:0] t;
        t = v + (v[55] ? 56'sd536870911 : 56'sd536870912);
        return t[55:30];
    endfunction

    function automatic logic [15:0] sat16(input logic signed [25:0] v);
        logic [15:0] q;
        if (v > 26'sd32767) begin
            q = 16'h7FFF;
        end else if (v < -26'sd32768) begin
            q = 16'h8000;
        end else begin
            q = v[15:0];
        end
        return q;
    endfunction

endpackage

### sv/swft_phase.sv
`timescale 1ns / 1ps

module swft_phase
    import swft_pkg::*;
#(
    parameter int SINE_TABLE_ENTRIES = SINE_TABLE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [15:0] i_phase,
    input  t_ends       i_ends,
    input  logic [12:0] i_clearance,
    output logic        o_valid,
    output logic [15:0] o_r,
    output t_geom       o_geom
);

    localparam int IW = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int PW = 15 + IW;

    logic [15:0] w_sine [0:SINE_TABLE_ENTRIES];

    for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++) begin : g_sine
        localparam logic [63:0] XK = HALF_PI_Q30 * 64'(k) / 64'(SINE_TABLE_ENTRIES);
        localparam logic [15:0] SV = sine_q15(XK);
        assign w_sine[k] = SV;
    end

    logic [15:0]   w_p;
    logic          w_low;
    logic [14:0]   w_pl;
    logic [PW-1:0] w_pos;
    logic [IW-1:0] w_idx;
    logic [IW-1:0] w_idx_b;
    logic [14:0]   w_hd;
    logic [29:0]   w_hp;
    logic [15:0]   w_rh;

    always_comb begin
        w_p = (i_phase > Q15_ONE) ? Q15_ONE : i_phase;
        w_low = (w_p <= Q15_HALF);
        w_pl = w_low ? w_p[14:0] : 15'd0;
        w_pos = PW'(w_pl) * PW'(SINE_TABLE_ENTRIES);
        w_idx = w_pos[13+IW:14];
        w_idx_b = (w_idx == IW'(SINE_TABLE_ENTRIES)) ? w_idx : w_idx + 1'b1;
        w_hd = w_low ? 15'd0 : 15'(w_p - Q15_HALF);
        w_hp = 30'(w_hd) * 30'(K_0P4) + 30'd16384;
        w_rh = K_0P8 + 16'(w_hp[29:15]);
    end

    logic          r1_valid, r2_valid, r3_valid, r4_valid;
    logic          r1_low, r2_low, r3_low;
    logic [IW-1:0] r1_idx, r1_idx_b;
    logic [13:0]   r1_frac, r2_frac;
    logic [15:0]   r1_rh, r2_rh, r3_rh;
    t_geom         r1_geom, r2_geom, r3_geom, r4_geom;
    logic [15:0]   r2_a, r2_b, r3_s, r4_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_low <= w_low;
        r1_idx <= w_idx;
        r1_idx_b <= w_idx_b;
        r1_frac <= w_pos[13:0];
        r1_rh <= w_rh;
        r1_geom <= geom_prep(i_ends, i_clearance);
    end

    always_ff @(posedge i_clk) begin
        r2_a <= w_sine[r1_idx];
        r2_b <= w_sine[r1_idx_b];
        r2_low <= r1_low;
        r2_frac <= r1_frac;
        r2_rh <= r1_rh;
        r2_geom <= r1_geom;
    end

    logic        w_ge;
    logic [15:0] w_d;
    logic [29:0] w_prod;
    logic [15:0] w_s;

    always_comb begin
        w_ge = (r2_b >= r2_a);
        w_d = w_ge ? (r2_b - r2_a) : (r2_a - r2_b);
        w_prod = 30'(w_d) * 30'(r2_frac);
        w_s = w_ge ? (r2_a + w_prod[29:14]) : (r2_a - w_prod[29:14]);
    end

    always_ff @(posedge i_clk) begin
        r3_s <= w_s;
        r3_low <= r2_low;
        r3_rh <= r2_rh;
        r3_geom <= r2_geom;
    end

    logic [31:0] w_rl;

    assign w_rl = 32'(r3_s) * 32'(K_0P8) + 32'd16384;

    always_ff @(posedge i_clk) begin
        r4_r <= r3_low ? 16'(w_rl[31:15]) : r3_rh;
        r4_geom <= r3_geom;
    end

    assign o_valid = r4_valid;
    assign o_r = r4_r;
    assign o_geom = r4_geom;

endmodule

### sv/swft_interp.sv
`timescale 1ns / 1ps

module swft_interp
    import swft_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [15:0] i_r,
    input  t_geom       i_geom,
    output logic        o_valid,
    output logic [15:0] o_foot_x,
    output logic [15:0] o_foot_y,
    output logic [15:0] o_foot_z
);

    logic signed [16:0] w_r;

    assign w_r = $signed({1'b0, i_r});

    logic                r5_valid, r6_valid, r7_valid, r8_valid;
    logic signed [33:0]  r5_rdx, r5_rdy;
    logic [31:0]         r5_r2;
    logic signed [37:0]  r5_cbr, r6_cbr;
    logic signed [15:0]  r5_sx, r5_sy, r5_sz, r6_sz;
    logic signed [20:0]  r5_ca;
    logic signed [35:0]  r6_x, r6_y;
    logic signed [52:0]  r6_car2;
    logic signed [55:0]  r7_z;
    logic [15:0]         r7_fx, r7_fy;
    logic [15:0]         r8_fx, r8_fy, r8_fz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
            r8_valid <= 1'b0;
        end else begin
            r5_valid <= i_valid;
            r6_valid <= r5_valid;
            r7_valid <= r6_valid;
            r8_valid <= r7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_rdx <= 34'(w_r) * 34'(i_geom.dx);
        r5_rdy <= 34'(w_r) * 34'(i_geom.dy);
        r5_r2 <= 32'(i_r) * 32'(i_r);
        r5_cbr <= 38'(i_geom.cb) * 38'(w_r);
        r5_sx <= i_geom.sx;
        r5_sy <= i_geom.sy;
        r5_sz <= i_geom.sz;
        r5_ca <= i_geom.ca;
    end

    always_ff @(posedge i_clk) begin
        r6_x <= (36'(r5_sx) <<< 15) + 36'(r5_rdx);
        r6_y <= (36'(r5_sy) <<< 15) + 36'(r5_rdy);
        r6_car2 <= 53'(r5_ca) * $signed({21'd0, r5_r2});
        r6_cbr <= r5_cbr;
        r6_sz <= r5_sz;
    end

    always_ff @(posedge i_clk) begin
        r7_z <= 56'(r6_car2) + (56'(r6_cbr) <<< 15) + (56'(r6_sz) <<< 30);
        r7_fx <= sat16(26'(round_q15(r6_x)));
        r7_fy <= sat16(26'(round_q15(r6_y)));
    end

    always_ff @(posedge i_clk) begin
        r8_fx <= r7_fx;
        r8_fy <= r7_fy;
        r8_fz <= sat16(round_q30(r7_z));
    end

    assign o_valid = r8_valid;
    assign o_foot_x = r8_fx;
    assign o_foot_y = r8_fy;
    assign o_foot_z = r8_fz;

endmodule

### sv/swing_foot_trajectory.sv
`timescale 1ns / 1ps

// Swing-foot trajectory point generator. Each transfer on start returns one foot position
// on o_foot_x, o_foot_y and o_foot_z, marked by o_valid for a single cycle. A new item is
// taken in every clock cycle while busy is low: the eight-stage pipeline (phase clamp, sine
// table read, table interpolation, phase remap, then four multiply and round stages) has no
// feedback, so the rate is one point per cycle while busy is low. Results cannot be held off,
// so the receiver must take o_valid as it comes. busy is high only while reset is applied
// and for the cycle after; the max_clearance register is written through i_cfg_valid and
// o_cfg_ready and must only be changed while no item is in flight.
module swing_foot_trajectory
    import swft_pkg::*;
#(
    parameter int SINE_TABLE_ENTRIES = SINE_TABLE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_swing_phase,
    input  logic [15:0] i_start_x,
    input  logic [15:0] i_start_y,
    input  logic [15:0] i_start_z,
    input  logic [15:0] i_end_x,
    input  logic [15:0] i_end_y,
    input  logic [15:0] i_end_z,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_max_clearance,
    output logic        o_valid,
    output logic [15:0] o_foot_x,
    output logic [15:0] o_foot_y,
    output logic [15:0] o_foot_z
);

    logic        r_run;
    logic [12:0] r_clearance;
    logic        w_accept;
    t_ends       w_ends;
    logic        w_ph_valid;
    logic [15:0] w_ph_r;
    t_geom       w_ph_geom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_clearance <= CLEAR_RESET;
        end else begin
            r_run <= 1'b1;
            if (i_cfg_valid && r_run) begin
                r_clearance <= i_cfg_max_clearance;
            end
        end
    end

    assign busy = !r_run;
    assign o_cfg_ready = r_run;
    assign w_accept = start && r_run;

    assign w_ends.sx = $signed(i_start_x);
    assign w_ends.sy = $signed(i_start_y);
    assign w_ends.sz = $signed(i_start_z);
    assign w_ends.ex = $signed(i_end_x);
    assign w_ends.ey = $signed(i_end_y);
    assign w_ends.ez = $signed(i_end_z);

    swft_phase #(
        .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
    ) u_phase (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_accept),
        .i_phase    (i_swing_phase),
        .i_ends     (w_ends),
        .i_clearance(r_clearance),
        .o_valid    (w_ph_valid),
        .o_r        (w_ph_r),
        .o_geom     (w_ph_geom)
    );

    swft_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ph_valid),
        .i_r     (w_ph_r),
        .i_geom  (w_ph_geom),
        .o_valid (o_valid),
        .o_foot_x(o_foot_x),
        .o_foot_y(o_foot_y),
        .o_foot_z(o_foot_z)
    );

endmodule

### sv/swft_checker.sv
`timescale 1ns / 1ps

module swft_checker
    import swft_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [15:0] i_swing_phase,
    input logic [15:0] i_start_x,
    input logic [15:0] i_start_y,
    input logic        o_valid,
    input logic [15:0] o_foot_x,
    input logic [15:0] o_foot_y
);

    logic [3:0] r_age;
    logic       w_settled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age <= '0;
        end else if (r_age != 4'(LATENCY + 1)) begin
            r_age <= r_age + 1'b1;
        end
    end

    assign w_settled = (r_age == 4'(LATENCY + 1));

    // Every result matches an earlier transfer on start.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_settled && o_valid) |-> $past(start && !busy, LATENCY))
        else $error("result without a matching transfer");

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_settled && $past(start && !busy, LATENCY)) |-> o_valid)
        else $error("transfer produced no result");

    // At zero phase the foot sits at the start position.
    a_phase_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_settled && $past(start && !busy && i_swing_phase == 16'd0, LATENCY))
        |-> (o_foot_x == $past(i_start_x, LATENCY) && o_foot_y == $past(i_start_y, LATENCY)))
        else $error("zero phase does not return the start position");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown straight after reset");

endmodule

bind swing_foot_trajectory swft_checker u_swft_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_swing_phase(i_swing_phase),
    .i_start_x    (i_start_x),
    .i_start_y    (i_start_y),
    .o_valid      (o_valid),
    .o_foot_x     (o_foot_x),
    .o_foot_y     (o_foot_y)
);

### tb/swing_foot_trajectory_checker.sv
`timescale 1ns / 1ps

module swing_foot_trajectory_checker
    import swft_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [15:0] i_swing_phase,
    input  logic [15:0] i_start_x,
    input  logic [15:0] i_start_y,
    input  logic [15:0] i_start_z,
    input  logic [15:0] i_end_x,
    input  logic [15:0] i_end_y,
    input  logic [15:0] i_end_z,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [12:0] i_cfg_max_clearance,
    input  logic        i_valid,
    input  logic [15:0] i_foot_x,
    input  logic [15:0] i_foot_y,
    input  logic [15:0] i_foot_z,
    output int          o_mismatches,
    output int          o_outstanding
);

    localparam int TABLE_SIZE = SINE_TABLE_ENTRIES_DEF;
    localparam int TW = $clog2(TABLE_SIZE + 1);

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
    } t_foot_point;

    logic [15:0] quarter_sine [0:TABLE_SIZE];
    logic [12:0] clearance;
    t_foot_point expected_points [$];

    // Quarter-wave sine of the table points, from a thirteen-term Taylor series in Q30.
    initial begin : build_table
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint unsigned rounded;
        longint sum;
        for (int k = 0; k <= TABLE_SIZE; k++) begin
            ang = HALF_PI_Q30 * 64'(k) / 64'(TABLE_SIZE);
            ang_sq = (ang * ang) >> 30;
            term = ang;
            sum = longint'(ang);
            for (int n = 1; n <= 12; n++) begin
                term = ((term * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            rounded = ($unsigned(sum) + 64'd16384) >> 15;
            if (rounded > 64'(Q15_ONE)) begin
                rounded = 64'(Q15_ONE);
            end
            quarter_sine[k] = rounded[15:0];
        end
    end

    // Rounds v / 2^sh to the nearest integer, a tie going away from zero, then saturates.
    function automatic logic [15:0] to_q12(input longint v, input int sh);
        longint half;
        longint q;
        half = longint'(1) <<< (sh - 1);
        q = (v >= 0) ? ((v + half) >>> sh) : -((half - v) >>> sh);
        if (q > 32767) begin
            q = 32767;
        end else if (q < -32768) begin
            q = -32768;
        end
        return q[15:0];
    endfunction

    task automatic flag(input string msg);
        if (o_mismatches < 10) begin
            $display("%t: %s", $realtime, msg);
        end
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin : track
        longint unsigned p;
        longint unsigned pos;
        longint unsigned idx;
        longint unsigned frac;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned s;
        longint r;
        longint sx;
        longint sy;
        longint sz;
        longint ex;
        longint ey;
        longint ez;
        longint peak;
        longint d_end;
        longint d_mid;
        longint ca;
        longint cb;
        t_foot_point want;
        t_foot_point got;
        if (!i_rst_n) begin
            clearance = CLEAR_RESET;
            expected_points.delete();
            o_outstanding = 0;
            o_mismatches = 0;
        end else begin
            if (i_start && !i_busy) begin
                p = 64'(i_swing_phase);
                if (p > 64'(Q15_ONE)) begin
                    p = 64'(Q15_ONE);
                end
                if (p <= 64'(Q15_HALF)) begin
                    pos = p * 64'(TABLE_SIZE);
                    idx = pos >> 14;
                    frac = pos & 64'h3FFF;
                    if (idx >= 64'(TABLE_SIZE)) begin
                        s = 64'(quarter_sine[TABLE_SIZE]);
                    end else begin
                        lo = 64'(quarter_sine[idx[TW-1:0]]);
                        hi = 64'(quarter_sine[TW'(idx + 64'd1)]);
                        if (hi >= lo) begin
                            s = lo + (((hi - lo) * frac) >> 14);
                        end else begin
                            s = lo - (((lo - hi) * frac) >> 14);
                        end
                    end
                    r = longint'((s * 64'(K_0P8) + 64'd16384) >> 15);
                end else begin
                    r = longint'(K_0P8)
                        + longint'(((p - 64'(Q15_HALF)) * 64'(K_0P4) + 64'd16384) >> 15);
                end
                sx = longint'($signed(i_start_x));
                sy = longint'($signed(i_start_y));
                sz = longint'($signed(i_start_z));
                ex = longint'($signed(i_end_x));
                ey = longint'($signed(i_end_y));
                ez = longint'($signed(i_end_z));
                peak = ((ez > sz) ? ez : sz) + longint'(clearance);
                d_end = ez - sz;
                d_mid = peak - sz;
                ca = 2 * d_end - 4 * d_mid;
                cb = 4 * d_mid - d_end;
                want.x = to_q12(sx * longint'(Q15_ONE) + r * (ex - sx), 15);
                want.y = to_q12(sy * longint'(Q15_ONE) + r * (ey - sy), 15);
                want.z = to_q12(ca * r * r + cb * r * longint'(Q15_ONE)
                                + sz * (longint'(1) <<< 30), 30);
                expected_points.push_back(want);
            end
            if (i_valid) begin
                got.x = i_foot_x;
                got.y = i_foot_y;
                got.z = i_foot_z;
                if (expected_points.size() == 0) begin
                    flag($sformatf("Result (%0d, %0d, %0d) arrived with no point pending.",
                                   $signed(got.x), $signed(got.y), $signed(got.z)));
                end else begin
                    want = expected_points.pop_front();
                    if (got !== want) begin
                        flag($sformatf("Foot point expected (%0d, %0d, %0d), got (%0d, %0d, %0d).",
                                       $signed(want.x), $signed(want.y), $signed(want.z),
                                       $signed(got.x), $signed(got.y), $signed(got.z)));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                clearance = i_cfg_max_clearance;
            end
            o_outstanding = expected_points.size();
        end
    end

endmodule

### tb/swing_foot_trajectory_test.sv
`timescale 1ns / 1ps

module swing_foot_trajectory_test;
    import swft_pkg::*;

    typedef struct packed {
        logic [15:0] phase;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] sz;
        logic [15:0] ex;
        logic [15:0] ey;
        logic [15:0] ez;
    } t_swing_item;

    localparam int SETTING_COUNT = 6;
    localparam int POINTS_PER_SETTING = 335;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] i_swing_phase = '0;
    logic [15:0] i_start_x = '0;
    logic [15:0] i_start_y = '0;
    logic [15:0] i_start_z = '0;
    logic [15:0] i_end_x = '0;
    logic [15:0] i_end_y = '0;
    logic [15:0] i_end_z = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [12:0] i_cfg_max_clearance = '0;
    logic        o_valid;
    logic [15:0] o_foot_x;
    logic [15:0] o_foot_y;
    logic [15:0] o_foot_z;

    int mismatches;
    int outstanding;
    int points_sent = 0;
    bit no_idle = 1'b0;

    logic [15:0] corner_phase [12] = '{16'd0, 16'd1, 16'd63, 16'd64, 16'd16383, 16'd16384,
                                      16'd16385, 16'd24576, 16'd32767, 16'd32768,
                                      16'd32769, 16'hFFFF};

    swing_foot_trajectory u_dut (
        .i_clk, .i_rst_n, .start, .busy,
        .i_swing_phase, .i_start_x, .i_start_y, .i_start_z, .i_end_x, .i_end_y, .i_end_z,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_max_clearance,
        .o_valid, .o_foot_x, .o_foot_y, .o_foot_z
    );

    swing_foot_trajectory_checker u_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (start),
        .i_busy              (busy),
        .i_swing_phase       (i_swing_phase),
        .i_start_x           (i_start_x),
        .i_start_y           (i_start_y),
        .i_start_z           (i_start_z),
        .i_end_x             (i_end_x),
        .i_end_y             (i_end_y),
        .i_end_z             (i_end_z),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_max_clearance (i_cfg_max_clearance),
        .i_valid             (o_valid),
        .i_foot_x            (o_foot_x),
        .i_foot_y            (o_foot_y),
        .i_foot_z            (o_foot_z),
        .o_mismatches        (mismatches),
        .o_outstanding       (outstanding)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_swing_item make_item(input logic [15:0] ph, input logic [15:0] sx,
                                              input logic [15:0] sy, input logic [15:0] sz,
                                              input logic [15:0] ex, input logic [15:0] ey,
                                              input logic [15:0] ez);
        t_swing_item it;
        it.phase = ph;
        it.sx = sx;
        it.sy = sy;
        it.sz = sz;
        it.ex = ex;
        it.ey = ey;
        it.ez = ez;
        return it;
    endfunction

    function automatic logic [15:0] pick_phase();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(16380, 16388));
            1: return 16'($urandom_range(32760, 32776));
            2, 3: return 16'($urandom);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2, 3: return 16'($urandom_range(0, 4095)) - 16'd2048;
            default: return 16'($urandom);
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the point is transferred.
    task automatic send_point(input t_swing_item it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_swing_phase <= it.phase;
        i_start_x <= it.sx;
        i_start_y <= it.sy;
        i_start_z <= it.sz;
        i_end_x <= it.ex;
        i_end_y <= it.ey;
        i_end_z <= it.ez;
        forever begin
            @(negedge i_clk);
            if (!busy) begin
                break;
            end
            @(posedge i_clk);
        end
        @(posedge i_clk);
        points_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (outstanding != 0);
        @(posedge i_clk);
    endtask

    task automatic write_clearance(input logic [12:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_max_clearance <= value;
        forever begin
            @(negedge i_clk);
            if (o_cfg_ready) begin
                break;
            end
            @(posedge i_clk);
        end
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [12:0] clear_plan [SETTING_COUNT];
        t_swing_item stride;
        int target;
        int n;
        clear_plan = '{CLEAR_RESET, 13'd0, 13'h1FFF, 13'd0, 13'd0, 13'd1};
        clear_plan[3] = 13'($urandom_range(1, 8190));
        clear_plan[4] = 13'($urandom_range(1, 8190));
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int setting = 0; setting < SETTING_COUNT; setting++) begin
            if (setting > 0) begin
                wait_drained();
                write_clearance(clear_plan[setting]);
            end
            if (setting == 0 || setting == 2) begin
                foreach (corner_phase[j]) begin
                    send_point(make_item(corner_phase[j], 16'h8000, 16'h7FFF, 16'h0000,
                                         16'h7FFF, 16'h8000, 16'h0000));
                end
                send_point(make_item(16'd16384, 16'd0, 16'd0, 16'h7FFF,
                                     16'd0, 16'd0, 16'h7FFF));
                send_point(make_item(16'd8192, 16'd0, 16'd0, 16'h7FFF,
                                     16'd0, 16'd0, 16'h7FFF));
                send_point(make_item(16'd0, 16'h8000, 16'h8000, 16'h8000,
                                     16'h8000, 16'h8000, 16'h8000));
                send_point(make_item(16'd32768, 16'h8000, 16'h8000, 16'h8000,
                                     16'h8000, 16'h8000, 16'h8000));
                send_point(make_item(16'd16384, 16'h7FFF, 16'h8000, 16'h7FFF,
                                     16'h8000, 16'h7FFF, 16'h8000));
                send_point(make_item(16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000,
                                     16'h7FFF, 16'h8000, 16'h7FFF));
            end
            target = points_sent + POINTS_PER_SETTING;
            while (points_sent < target) begin
                if ($urandom_range(0, 5) == 0) begin
                    no_idle = !no_idle;
                end
                if ($urandom_range(0, 39) == 0) begin
                    wait_drained();
                end
                if ($urandom_range(0, 4) == 0) begin
                    send_point(make_item(pick_phase(), pick_coord(), pick_coord(), pick_coord(),
                                         pick_coord(), pick_coord(), pick_coord()));
                end else begin
                    // A whole swing: fixed end points, phase stepping from zero to one.
                    stride = make_item(16'd0, pick_coord(), pick_coord(), pick_coord(),
                                       pick_coord(), pick_coord(), pick_coord());
                    n = $urandom_range(3, 16);
                    for (int j = 0; j < n; j++) begin
                        stride.phase = 16'((j * 32768) / (n - 1));
                        send_point(stride);
                    end
                end
            end
        end
        wait_drained();
        repeat (LATENCY + 4) @(posedge i_clk);
        $display("Run covered %0d trajectory points under %0d clearance settings,",
                 points_sent, SETTING_COUNT);
        $display("%s", {"from zero to the full 13-bit range, ",
                        "with phases past one and saturating heights."});
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Run stopped by timeout.");
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### swing_foot_trajectory.f
sv/swft_pkg.sv
sv/swft_phase.sv
sv/swft_interp.sv
sv/swing_foot_trajectory.sv
sv/swft_checker.sv
tb/swing_foot_trajectory_checker.sv
tb/swing_foot_trajectory_test.sv
